[design/merl_pkg.sv]
package merl_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_STORE = 2'd0;
   localparam logic [1:0] OP_LOSS  = 2'd1;
   localparam logic [1:0] OP_ACCUM = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Result kinds.
   localparam logic KIND_LOSS = 1'b0;
   localparam logic KIND_GRAD = 1'b1;

   // Default sizes and coordinate format of the engine.
   localparam int DEF_MAX_EDGES    = 4096;
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_FRAC_BITS    = 16;

   // Fraction bits of the edge weight.
   localparam int WEIGHT_FRAC = 24;
   // Width of a weighted deviation: a 64-bit product shifted right by the weight fraction.
   localparam int WD_W = 64 - WEIGHT_FRAC;

   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;
   localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] weight;
      logic [31:0] rest_z;
      logic [31:0] rest_y;
      logic [31:0] rest_x;
   } edge_word_type;

   typedef struct packed {
      logic [31:0] acc_z;
      logic [31:0] acc_y;
      logic [31:0] acc_x;
   } grad_word_type;

   // Saturate a 34-bit signed value to 32 bits.
   function automatic logic [31:0] sat32(input logic [33:0] v);
      logic [31:0] r;
      if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
         r = v[31:0];
      end else begin
         r = v[33] ? S32_MIN : S32_MAX;
      end
      return r;
   endfunction

   // Magnitude of a 32-bit signed value; the most negative value maps to 2^31.
   function automatic logic [31:0] mag32(input logic [31:0] v);
      logic [31:0] r;
      r = v[31] ? (32'd0 - v) : v;
      return r;
   endfunction

   // Saturating accumulator update: acc + delta or acc - delta.
   function automatic logic [31:0] acc_upd(input logic [31:0] acc, input logic [31:0] delta,
                                           input logic subtract);
      logic [33:0] a;
      logic [33:0] d;
      logic [33:0] s;
      a = {{2{acc[31]}}, acc};
      d = {{2{delta[31]}}, delta};
      s = subtract ? (a - d) : (a + d);
      return sat32(s);
   endfunction

endpackage

[design/mesh_edge_rest_loss_engine.sv]
// Edge rest-length loss and gradient engine. Each edge slot holds its rest offset
// (end minus start, signed Q16.16 per axis) and a weight of 0.02 over the rest length;
// each vertex holds a saturating gradient accumulator per axis. Opcode 0 stores an
// edge's rest shape, 1 returns the squared weighted deviation per axis (kind 0),
// 2 adds weight squared times deviation into the end vertex and subtracts it from the
// start vertex, and 3 returns a vertex gradient (kind 1) and clears it. One request is
// worked on at a time. A store forms the sum of squares, then the integer square root
// (one result bit a cycle) and then the weight by a 64-bit restoring divide. A loss or
// an accumulate passes each axis twice through the single shared 32x32 multiplier.
// After reset the gradient memory is cleared, one vertex a cycle, before the first
// request is taken. A response waits in the output register, so the next request may
// start while the previous response is still pending. Reading an edge slot never
// stored is undefined.
module mesh_edge_rest_loss_engine #(
   parameter int MAX_EDGES    = merl_pkg::DEF_MAX_EDGES,
   parameter int MAX_VERTICES = merl_pkg::DEF_MAX_VERTICES,
   parameter int FRAC_BITS    = merl_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [11:0] req_edge_index,
   input  logic [9:0]  req_start_vertex,
   input  logic [9:0]  req_end_vertex,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic signed [31:0] rsp_value_x,
   output logic signed [31:0] rsp_value_y,
   output logic signed [31:0] rsp_value_z
);
   import merl_pkg::*;

   localparam int EA = $clog2(MAX_EDGES);
   localparam int VA = $clog2(MAX_VERTICES);
   // Weight numerator: 0.02 scaled by the weight and coordinate fractions, rounded.
   localparam logic [63:0] KC =
      ((64'd1 << (WEIGHT_FRAC + FRAC_BITS + 1)) + 64'd50) / 64'd100;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_SQRT  = 4'd3;
   localparam logic [3:0] S_DIVI  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_EWR   = 4'd6;
   localparam logic [3:0] S_P1    = 4'd7;
   localparam logic [3:0] S_P2    = 4'd8;
   localparam logic [3:0] S_P3    = 4'd9;
   localparam logic [3:0] S_P4    = 4'd10;
   localparam logic [3:0] S_GRD   = 4'd11;
   localparam logic [3:0] S_ASV   = 4'd12;
   localparam logic [3:0] S_AEVR  = 4'd13;
   localparam logic [3:0] S_AEV   = 4'd14;
   localparam logic [3:0] S_RESP  = 4'd15;

   // Memories: rest offsets and weight per edge, gradient per vertex.
   edge_word_type edge_mem [MAX_EDGES];
   grad_word_type grad_mem [MAX_VERTICES];

   edge_word_type edge_rd_ff;
   grad_word_type grad_rd_ff;

   logic          er_en;
   logic [EA-1:0] er_addr;
   logic          ew_en;
   logic [EA-1:0] ew_addr;
   edge_word_type ew_data;
   logic          gr_en;
   logic [VA-1:0] gr_addr;
   logic          gw_en;
   logic [VA-1:0] gw_addr;
   grad_word_type gw_data;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    k_ff, k_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [VA-1:0] clr_ff, clr_in;
   logic [1:0]    op_ff, op_in;
   logic [EA-1:0] eaddr_ff, eaddr_in;
   logic [VA-1:0] sv_ff, sv_in;
   logic [VA-1:0] ev_ff, ev_in;
   logic          eok_ff, eok_in;
   logic          svok_ff, svok_in;
   logic          evok_ff, evok_in;
   logic signed [32:0] d_ff [3];
   logic signed [32:0] d_in [3];
   logic [63:0]   s_ff, s_in;
   logic [63:0]   v_ff, v_in;
   logic [63:0]   r_ff, r_in;
   logic [63:0]   bit_ff, bit_in;
   logic [31:0]   rem_ff, rem_in;
   logic [63:0]   quo_ff, quo_in;
   logic [63:0]   prod_ff, prod_in;
   logic [WD_W-1:0] wd_ff, wd_in;
   logic [31:0]   res_ff [3];
   logic [31:0]   res_in [3];
   logic          kind_ff, kind_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [31:0]   rsp_x_ff, rsp_x_in;
   logic [31:0]   rsp_y_ff, rsp_y_in;
   logic [31:0]   rsp_z_ff, rsp_z_in;

   // Per-axis datapath signals.
   logic signed [32:0] d_sel;
   logic [31:0]   rest_sel;
   logic [31:0]   o_sel;
   logic [33:0]   dev_wide;
   logic [31:0]   dev_sel;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   wsum;
   logic [64:0]   gsum;
   logic [64-WEIGHT_FRAC:0] g_raw;
   logic [32:0]   g_clamp;
   logic [33:0]   g_signed;
   logic [64:0]   lsum;
   logic [64:0]   lsh;
   logic [31:0]   axis_res;
   logic [63:0]   sq_try;
   logic [32:0]   rem_sh;
   logic          accept;

   assign req_ready       = (state_ff == S_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_value_x     = rsp_x_ff;
   assign rsp_value_y     = rsp_y_ff;
   assign rsp_value_z     = rsp_z_ff;

   // Axis selection.
   always_comb begin
      case (k_ff)
         2'd0: begin
            d_sel    = d_ff[0];
            rest_sel = edge_rd_ff.rest_x;
         end
         2'd1: begin
            d_sel    = d_ff[1];
            rest_sel = edge_rd_ff.rest_y;
         end
         default: begin
            d_sel    = d_ff[2];
            rest_sel = edge_rd_ff.rest_z;
         end
      endcase
   end

   assign o_sel    = sat32({d_sel[32], d_sel});
   assign dev_wide = {d_sel[32], d_sel} - {{2{rest_sel[31]}}, rest_sel};
   assign dev_sel  = sat32(dev_wide);

   // Rounding of the products: weighted deviation, gradient term and loss.
   assign wsum     = prod_ff + (64'd1 << (WEIGHT_FRAC - 1));
   assign gsum     = {1'b0, prod_ff} + (65'd1 << (WEIGHT_FRAC - 1));
   assign g_raw    = gsum[64:WEIGHT_FRAC];
   assign g_clamp  = (g_raw > (65 - WEIGHT_FRAC)'(33'h1_0000_0000 >> 1)) ?
                     33'h0_8000_0000 : g_raw[32:0];
   assign g_signed = dev_sel[31] ? (34'd0 - {1'b0, g_clamp}) : {1'b0, g_clamp};
   assign lsum     = {1'b0, prod_ff} + (65'd1 << (FRAC_BITS - 1));
   assign lsh      = lsum >> FRAC_BITS;

   always_comb begin
      if (op_ff == OP_LOSS) begin
         if ((|wd_ff[WD_W-1:31]) || (|lsh[64:31])) begin
            axis_res = S32_MAX;
         end else begin
            axis_res = lsh[31:0];
         end
      end else begin
         axis_res = sat32(g_signed);
      end
   end

   // Square root step and divide step.
   assign sq_try = r_ff + bit_ff;
   assign rem_sh = {rem_ff, quo_ff[63]};

   // The shared multiplier; its product is registered before any use.
   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      eaddr_in     = eaddr_ff;
      sv_in        = sv_ff;
      ev_in        = ev_ff;
      eok_in       = eok_ff;
      svok_in      = svok_ff;
      evok_in      = evok_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      wd_in        = wd_ff;
      res_in       = res_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      mul_a        = mag32(o_sel);
      mul_b        = mag32(o_sel);
      er_en        = 1'b0;
      er_addr      = EA'(req_edge_index);
      ew_en        = 1'b0;
      ew_addr      = eaddr_ff;
      ew_data.rest_x = sat32({d_ff[0][32], d_ff[0]});
      ew_data.rest_y = sat32({d_ff[1][32], d_ff[1]});
      ew_data.rest_z = sat32({d_ff[2][32], d_ff[2]});
      ew_data.weight = U32_MAX;
      gr_en        = 1'b0;
      gr_addr      = VA'(req_start_vertex);
      gw_en        = 1'b0;
      gw_addr      = sv_ff;
      gw_data      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            gw_en   = 1'b1;
            gw_addr = clr_ff;
            clr_in  = clr_ff + VA'(1);
            if (clr_ff == VA'(MAX_VERTICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               // Both memories are read right away; the data is ready in the next cycle.
               er_en    = 1'b1;
               gr_en    = 1'b1;
               op_in    = req_opcode;
               eaddr_in = EA'(req_edge_index);
               sv_in    = VA'(req_start_vertex);
               ev_in    = VA'(req_end_vertex);
               eok_in   = 32'(req_edge_index) < 32'(MAX_EDGES);
               svok_in  = 32'(req_start_vertex) < 32'(MAX_VERTICES);
               evok_in  = 32'(req_end_vertex) < 32'(MAX_VERTICES);
               d_in[0]  = 33'(req_end_x) - 33'(req_start_x);
               d_in[1]  = 33'(req_end_y) - 33'(req_start_y);
               d_in[2]  = 33'(req_end_z) - 33'(req_start_z);
               k_in     = 2'd0;
               s_in     = '0;
               unique case (req_opcode)
                  OP_STORE: begin
                     state_in = (32'(req_edge_index) < 32'(MAX_EDGES)) ? S_SQ : S_IDLE;
                  end
                  OP_READ: begin
                     state_in = S_GRD;
                  end
                  OP_LOSS: begin
                     if (32'(req_edge_index) < 32'(MAX_EDGES)) begin
                        state_in = S_P1;
                     end else begin
                        res_in[0] = '0;
                        res_in[1] = '0;
                        res_in[2] = '0;
                        kind_in   = KIND_LOSS;
                        state_in  = S_RESP;
                     end
                  end
                  default: begin
                     state_in = (32'(req_edge_index) < 32'(MAX_EDGES)) ? S_P1 : S_IDLE;
                  end
               endcase
            end
         end
         S_SQ: begin
            // One axis squared per cycle, each square summed in the cycle after, from the product register.
            if (k_ff != 2'd0) begin
               s_in = s_ff + prod_ff;
            end
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               v_in     = s_ff + prod_ff;
               r_in     = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (v_ff >= sq_try) begin
               v_in = v_ff - sq_try;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            if (r_ff[31:0] == 32'd0) begin
               // Zero rest length: the weight saturates.
               ew_en    = 1'b1;
               state_in = S_IDLE;
            end else begin
               rem_in   = '0;
               quo_in   = KC + {33'd0, r_ff[31:1]};
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, r_ff[31:0]}) begin
               rem_in = 32'(rem_sh - {1'b0, r_ff[31:0]});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_EWR;
            end
         end
         S_EWR: begin
            ew_en          = 1'b1;
            ew_data.weight = (|quo_ff[63:32]) ? U32_MAX : quo_ff[31:0];
            state_in       = S_IDLE;
         end
         S_P1: begin
            mul_a    = mag32(dev_sel);
            mul_b    = edge_rd_ff.weight;
            state_in = S_P2;
         end
         S_P2: begin
            wd_in    = wsum[63:WEIGHT_FRAC];
            state_in = S_P3;
         end
         S_P3: begin
            if (op_ff == OP_LOSS) begin
               mul_a = {1'b0, wd_ff[30:0]};
               mul_b = {1'b0, wd_ff[30:0]};
            end else begin
               mul_a = (|wd_ff[WD_W-1:32]) ? U32_MAX : wd_ff[31:0];
               mul_b = edge_rd_ff.weight;
            end
            state_in = S_P4;
         end
         S_P4: begin
            res_in[k_ff] = axis_res;
            k_in         = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               if (op_ff == OP_LOSS) begin
                  kind_in  = KIND_LOSS;
                  state_in = S_RESP;
               end else begin
                  state_in = S_ASV;
               end
            end else begin
               state_in = S_P1;
            end
         end
         S_GRD: begin
            kind_in = KIND_GRAD;
            if (svok_ff) begin
               res_in[0] = grad_rd_ff.acc_x;
               res_in[1] = grad_rd_ff.acc_y;
               res_in[2] = grad_rd_ff.acc_z;
               gw_en     = 1'b1;
            end else begin
               res_in[0] = '0;
               res_in[1] = '0;
               res_in[2] = '0;
            end
            state_in = S_RESP;
         end
         S_ASV: begin
            // The start vertex was read at acceptance; nothing has written it since.
            gw_en          = svok_ff;
            gw_data.acc_x  = acc_upd(grad_rd_ff.acc_x, res_ff[0], 1'b1);
            gw_data.acc_y  = acc_upd(grad_rd_ff.acc_y, res_ff[1], 1'b1);
            gw_data.acc_z  = acc_upd(grad_rd_ff.acc_z, res_ff[2], 1'b1);
            state_in       = S_AEVR;
         end
         S_AEVR: begin
            // Read the end vertex only after the start vertex write has landed.
            gr_en    = 1'b1;
            gr_addr  = ev_ff;
            state_in = S_AEV;
         end
         S_AEV: begin
            gw_en          = evok_ff;
            gw_addr        = ev_ff;
            gw_data.acc_x  = acc_upd(grad_rd_ff.acc_x, res_ff[0], 1'b0);
            gw_data.acc_y  = acc_upd(grad_rd_ff.acc_y, res_ff[1], 1'b0);
            gw_data.acc_z  = acc_upd(grad_rd_ff.acc_z, res_ff[2], 1'b0);
            state_in       = S_IDLE;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_x_in     = res_ff[0];
               rsp_y_in     = res_ff[1];
               rsp_z_in     = res_ff[2];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      eaddr_ff    <= eaddr_in;
      sv_ff       <= sv_in;
      ev_ff       <= ev_in;
      eok_ff      <= eok_in;
      svok_ff     <= svok_in;
      evok_ff     <= evok_in;
      d_ff        <= d_in;
      s_ff        <= s_in;
      v_ff        <= v_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      wd_ff       <= wd_in;
      res_ff      <= res_in;
      kind_ff     <= kind_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
   end

   // Edge memory with a registered read.
   always_ff @(posedge clock) begin
      if (ew_en) begin
         edge_mem[ew_addr] <= ew_data;
      end
      if (er_en) begin
         edge_rd_ff <= edge_mem[er_addr];
      end
   end

   // Gradient memory with a registered read.
   always_ff @(posedge clock) begin
      if (gw_en) begin
         grad_mem[gw_addr] <= gw_data;
      end
      if (gr_en) begin
         grad_rd_ff <= grad_mem[gr_addr];
      end
   end

endmodule
